### hw/rtl/tcf_pkg.sv
// Shared types and constants for the tilt complementary filter.
// No dependencies.
package tcf_pkg;
    localparam int RATE_W = 20;
    localparam int ACC_W = 16;
    localparam int ANG_W = 32;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CORDIC_STEPS = 20;
    localparam int STEP_W = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int GATE_LOW = 2048;
    localparam int GATE_HIGH = 8192;
    // Deep enough for the 24-bit root plus CORDIC gain headroom.
    localparam int CX_W = 26;
    localparam int Z_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_WEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;

    localparam logic [CFG_W-1:0] GYRO_WEIGHT_RST = 16'd64881;
    localparam logic [CFG_W-1:0] ACCEL_WEIGHT_RST = 16'd655;
    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd1966;

    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        logic signed [ACC_W-1:0]  accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [ANG_W-1:0] pitch_angle;
        logic signed [ANG_W-1:0] roll_angle;
        logic                    accel_used;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        logic signed [ACC_W-1:0]  accel_z;
        logic                     gate_open;
    } t_job;

    typedef enum logic [3:0] {
        S_IDLE, S_INTEG, S_SQ_R, S_SQRT_R, S_CORD_R,
        S_SQ_P, S_SQRT_P, S_CORD_P, S_BLEND_R, S_BLEND_P, S_BLEND_W, S_OUT
    } t_state;

    function automatic logic signed [Z_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        begin
            unique case (i)
                5'd0: v = 24'sd2949120;
                5'd1: v = 24'sd1740967;
                5'd2: v = 24'sd919879;
                5'd3: v = 24'sd466945;
                5'd4: v = 24'sd234379;
                5'd5: v = 24'sd117304;
                5'd6: v = 24'sd58666;
                5'd7: v = 24'sd29335;
                5'd8: v = 24'sd14668;
                5'd9: v = 24'sd7334;
                5'd10: v = 24'sd3667;
                5'd11: v = 24'sd1833;
                5'd12: v = 24'sd917;
                5'd13: v = 24'sd458;
                5'd14: v = 24'sd229;
                5'd15: v = 24'sd115;
                5'd16: v = 24'sd57;
                5'd17: v = 24'sd29;
                5'd18: v = 24'sd14;
                5'd19: v = 24'sd7;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [ANG_W-1:0] sat32(input logic signed [49:0] v);
        begin
            if (v > 50'sd2147483647) return 32'sh7fffffff;
            if (v < -50'sd2147483648) return 32'sh80000000;
            return v[ANG_W-1:0];
        end
    endfunction
endpackage

### hw/rtl/tcf_if.sv
// Valid/ready channel carrying one payload.
// Depends on nothing; payload type is a parameter.
interface tcf_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tcf_front.sv
// Front end: accepts samples, evaluates the accel magnitude gate, queues jobs.
// Depends on tcf_pkg.
module tcf_front import tcf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tcf_if.sink      in_ch,
    output logic     o_job_valid,
    output t_job     o_job,
    input  logic     i_job_pop
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    t_job r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0] r_cnt;
    logic [ACC_W-1:0] ax_abs, ay_abs, az_abs;
    logic [ACC_W+1:0] mag;
    logic push;
    t_job job;

    always_comb begin
        ax_abs = in_ch.data.accel_x[ACC_W-1] ? ACC_W'(-in_ch.data.accel_x) : in_ch.data.accel_x;
        ay_abs = in_ch.data.accel_y[ACC_W-1] ? ACC_W'(-in_ch.data.accel_y) : in_ch.data.accel_y;
        az_abs = in_ch.data.accel_z[ACC_W-1] ? ACC_W'(-in_ch.data.accel_z) : in_ch.data.accel_z;
        mag = (ACC_W+2)'(ax_abs) + (ACC_W+2)'(ay_abs) + (ACC_W+2)'(az_abs);
        job.rate_x = in_ch.data.rate_x;
        job.rate_y = in_ch.data.rate_y;
        job.accel_x = in_ch.data.accel_x;
        job.accel_y = in_ch.data.accel_y;
        job.accel_z = in_ch.data.accel_z;
        job.gate_open = (mag > (ACC_W+2)'(GATE_LOW)) && (mag < (ACC_W+2)'(GATE_HIGH));
    end

    assign in_ch.ready = (r_cnt != (PTR_W+1)'(QUEUE_DEPTH));
    assign push = in_ch.valid && in_ch.ready;
    assign o_job_valid = (r_cnt != '0);
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= job;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_job_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PTR_W+1)'(push) - (PTR_W+1)'(i_job_pop);
        end
    end
endmodule

### hw/rtl/tcf_back.sv
// Back end: integration, sqrt, CORDIC and blend on a shared sequencer.
// Depends on tcf_pkg.
module tcf_back import tcf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_job_pop,
    input  logic [CFG_W-1:0] i_gyro_weight,
    input  logic [CFG_W-1:0] i_accel_weight,
    input  logic [CFG_W-1:0] i_sample_period,
    tcf_if.source            out_ch
);
    t_state r_state, n_state;
    t_job r_job;
    logic signed [ANG_W-1:0] r_pitch, r_roll;
    logic r_used;
    logic [STEP_W-1:0] r_step;
    // sqrt unit
    logic [47:0] r_rem;
    logic [23:0] r_root;
    logic [47:0] r_sqv;
    // cordic
    logic signed [CX_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0] r_z, r_roll_acc;
    // blend products
    logic signed [49:0] r_prod;

    logic signed [ACC_W-1:0] sa, sb, sc;
    logic signed [31:0] sq_a, sq_b;
    logic [48:0] trial;
    logic signed [CX_W-1:0] xs, ys;
    logic signed [41:0] ig_x, ig_y;
    logic signed [ANG_W+1:0] roll_i, pitch_i;
    logic signed [49:0] mul_g, mul_a;
    logic signed [49:0] blend;
    logic [1:0] bits;

    always_comb begin
        // rates in Q.8 times dt Q.16, rounded to Q.16
        ig_x = r_job.rate_x * $signed({1'b0, i_sample_period}) + 42'sd128;
        ig_y = r_job.rate_y * $signed({1'b0, i_sample_period}) + 42'sd128;
        roll_i = (ANG_W+2)'(r_roll) + (ANG_W+2)'(ig_x >>> 8);
        pitch_i = (ANG_W+2)'(r_pitch) - (ANG_W+2)'(ig_y >>> 8);
        // operand choice: roll uses (ax, az, ay), pitch uses (ay, az, ax)
        sa = (r_state == S_SQ_R) ? r_job.accel_x : r_job.accel_y;
        sb = r_job.accel_z;
        sc = (r_state == S_SQ_R || r_state == S_SQRT_R || r_state == S_CORD_R) ?
             r_job.accel_y : r_job.accel_x;
        sq_a = sa * sa;
        sq_b = sb * sb;
        // bit pair of the radicand brought down this step
        bits = r_sqv[47:46];
        trial = {r_rem[46:0], bits} - {23'd0, r_root, 2'b01};
        xs = r_x >>> r_step;
        ys = r_y >>> r_step;
        mul_g = (r_state == S_BLEND_R) ? 50'(r_roll) * $signed({1'b0, i_gyro_weight})
                                       : 50'(r_pitch) * $signed({1'b0, i_gyro_weight});
        mul_a = (r_state == S_BLEND_R) ? 50'(r_roll_acc) * $signed({1'b0, i_accel_weight})
                                       : 50'(r_z) * $signed({1'b0, i_accel_weight});
        blend = r_prod + 50'sd32768;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_job_valid) n_state = S_INTEG;
            S_INTEG:   n_state = r_job.gate_open ? S_SQ_R : S_OUT;
            S_SQ_R:    n_state = S_SQRT_R;
            S_SQRT_R:  if (r_step == STEP_W'(23)) n_state = S_CORD_R;
            S_CORD_R:  if (r_step == STEP_W'(CORDIC_STEPS-1)) n_state = S_SQ_P;
            S_SQ_P:    n_state = S_SQRT_P;
            S_SQRT_P:  if (r_step == STEP_W'(23)) n_state = S_CORD_P;
            S_CORD_P:  if (r_step == STEP_W'(CORDIC_STEPS-1)) n_state = S_BLEND_R;
            S_BLEND_R: n_state = S_BLEND_P;
            S_BLEND_P: n_state = S_BLEND_W;
            S_BLEND_W: n_state = S_OUT;
            S_OUT:     if (out_ch.ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = (r_state == S_IDLE) && i_job_valid;
        out_ch.valid = (r_state == S_OUT);
        out_ch.data.pitch_angle = r_pitch;
        out_ch.data.roll_angle = r_roll;
        out_ch.data.accel_used = r_used;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pitch <= '0;
            r_roll <= '0;
            r_used <= 1'b0;
            r_step <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) r_job <= i_job;
                end
                S_INTEG: begin
                    r_roll <= sat32(50'(roll_i));
                    r_pitch <= sat32(50'(pitch_i));
                    r_used <= r_job.gate_open;
                end
                S_SQ_R, S_SQ_P: begin
                    r_sqv <= {($unsigned(sq_a) + $unsigned(sq_b)), 16'd0};
                    r_rem <= '0;
                    r_root <= '0;
                    r_step <= '0;
                end
                S_SQRT_R, S_SQRT_P: begin
                    r_sqv <= {r_sqv[45:0], 2'b00};
                    if (!trial[48]) begin
                        r_rem <= trial[47:0];
                        r_root <= {r_root[22:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[45:0], bits};
                        r_root <= {r_root[22:0], 1'b0};
                    end
                    if (r_step == STEP_W'(23)) begin
                        r_step <= '0;
                        r_x <= CX_W'({1'b0, trial[48] ? {r_root[22:0], 1'b0}
                                                       : {r_root[22:0], 1'b1}});
                        r_y <= CX_W'(sc) <<< 8;
                        r_z <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_CORD_R, S_CORD_P: begin
                    if (r_y > 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_deg(r_step);
                    end else if (r_y < 0) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_deg(r_step);
                    end
                    if (r_step == STEP_W'(CORDIC_STEPS-1)) begin
                        r_step <= '0;
                        if (r_state == S_CORD_R) r_roll_acc <= (r_y > 0) ?
                            r_z + atan_deg(r_step) : (r_y < 0) ? r_z - atan_deg(r_step) : r_z;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_BLEND_R: begin
                    r_prod <= mul_g + mul_a;
                end
                S_BLEND_P: begin
                    r_roll <= sat32(blend >>> 16);
                    r_prod <= mul_g + mul_a;
                end
                S_BLEND_W: begin
                    r_pitch <= sat32(blend >>> 16);
                end
                default: ;
            endcase
        end
    end
endmodule

### hw/rtl/tilt_complementary_filter_unit.sv
// Tilt complementary filter, top level: config registers, front end, back end.
// Depends on tcf_pkg, tcf_if, tcf_front, tcf_back.
//
// Usage: samples (two gyro rates, three accel axes) enter on in_ch; one result
// (pitch, roll, accel_used) leaves on out_ch per sample. Config writes go on
// i_cfg_we/i_cfg_idx/i_cfg_data while the block is idle; out-of-range indexes
// are dropped.
// Sequence: an accepted sample is first integrated. With the accel gate closed
// the result follows the integration step; with it open the back end then runs
// two 24-step square roots, two 20-step CORDIC runs and three blend steps, all on
// the single shared sqrt/CORDIC sequencer in the back end.
// Throughput: one request in the back end at a time; the next is taken only once
// the result has left on out_ch, and the front queue holds two more requests.
// Reset clears both estimates to zero and loads the register defaults.
// A stalled receiver holds the result on out_ch; the back end waits and the
// front queue fills, then in_ch.ready drops.
module tilt_complementary_filter_unit import tcf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tcf_if.sink                  in_ch,
    tcf_if.source                out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic [CFG_W-1:0] r_gyro_weight, r_accel_weight, r_sample_period;
    logic job_valid, job_pop;
    t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_weight <= GYRO_WEIGHT_RST;
            r_accel_weight <= ACCEL_WEIGHT_RST;
            r_sample_period <= SAMPLE_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GYRO_WEIGHT:   r_gyro_weight <= i_cfg_data;
                CFG_ACCEL_WEIGHT:  r_accel_weight <= i_cfg_data;
                CFG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tcf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_job_valid(job_valid), .o_job(job), .i_job_pop(job_pop)
    );

    tcf_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job(job), .o_job_pop(job_pop),
        .i_gyro_weight(r_gyro_weight), .i_accel_weight(r_accel_weight),
        .i_sample_period(r_sample_period), .out_ch(out_ch)
    );
endmodule

### hw/rtl/tcf_checker.sv
// Port-level checker for the tilt complementary filter, bound to the top level.
// Depends on tcf_pkg.
module tcf_checker import tcf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_used,
    input logic signed [ANG_W-1:0] out_pitch
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pitch))
        else $error("result dropped under stall");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !out_valid)
        else $error("result after reset");
    a_no_back2back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");
    a_used_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !$isunknown(out_used))
        else $error("accel_used unknown");
    a_accept_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(in_valid && in_ready))
        else $error("input handshake unknown");
endmodule

bind tilt_complementary_filter_unit tcf_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_used(out_ch.data.accel_used), .out_pitch(out_ch.data.pitch_angle)
);
